[src/ssoo_pkg.sv]
package ssoo_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    // two scaled products plus the drive term
    localparam int SUM_W     = SHIFT_W + 2;
    localparam int CFG_IDX_W = 8;

    typedef logic signed [DATA_W-1:0] t_fix;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A00  = 8'd0,
        REG_A01  = 8'd1,
        REG_A10  = 8'd2,
        REG_A11  = 8'd3,
        REG_B0   = 8'd4,
        REG_B1   = 8'd5,
        REG_THR  = 8'd6,
        REG_INIT = 8'd7
    } t_reg_idx;

    localparam t_fix RST_A00  = 32'sd62259;
    localparam t_fix RST_A01  = 32'sd0;
    localparam t_fix RST_A10  = 32'sd0;
    localparam t_fix RST_A11  = 32'sd65536;
    localparam t_fix RST_B0   = 32'sd72090;
    localparam t_fix RST_B1   = 32'sd327680;
    localparam t_fix RST_THR  = 32'sd1310720;
    localparam t_fix RST_INIT = 32'sd786432;

    localparam t_fix FIX_MAX = 32'sh7fff_ffff;
    localparam t_fix FIX_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_fix a00;
        t_fix a01;
        t_fix a10;
        t_fix a11;
        t_fix b0;
        t_fix b1;
        t_fix thr;
        t_fix init;
    } t_coefs;

    typedef struct packed {
        t_fix level;
        t_fix cost;
        logic drive;
        logic saturated;
    } t_step;

endpackage

[src/ssoo_ifs.sv]
interface ssoo_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface ssoo_out_if;
    logic          valid;
    logic          ready;
    ssoo_pkg::t_fix level;
    ssoo_pkg::t_fix cost;
    logic          drive;
    logic          saturated;

    modport source (output valid, output level, output cost, output drive,
                    output saturated, input ready);
    modport sink   (input valid, input level, input cost, input drive,
                    input saturated, output ready);
endinterface

interface ssoo_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ssoo_pkg::CFG_IDX_W-1:0] index;
    logic [ssoo_pkg::DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/state_space_on_off_step_unit.sv]
// A result is valid the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the state feeds back
// combinationally through the four parallel 32x32 multipliers, row adders and saturation.
// Input ready stays high while the result register is empty or being taken.
// Reset (synchronous, active low): registers to defaults, level to the default
// initial level, cost to zero, no result pending.
module state_space_on_off_step_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssoo_in_if.sink     i_item,
    ssoo_out_if.source  o_result,
    ssoo_cfg_if.sink    i_cfg
);

    ssoo_pkg::t_coefs coefs;
    ssoo_pkg::t_step  n_step;
    ssoo_pkg::t_fix   r_level;
    ssoo_pkg::t_fix   r_cost;
    logic             r_out_valid;
    logic             r_drive;
    logic             r_saturated;
    logic             xfer_in;

    ssoo_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_coefs (coefs)
    );

    ssoo_step_calc u_calc (
        .i_coefs   (coefs),
        .i_level   (r_level),
        .i_cost    (r_cost),
        .i_restart (i_item.restart),
        .o_step    (n_step)
    );

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign xfer_in      = i_item.valid && i_item.ready;

    // the state registers double as the result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= ssoo_pkg::RST_INIT;
            r_cost      <= '0;
        end else if (xfer_in) begin
            r_out_valid <= 1'b1;
            r_level     <= n_step.level;
            r_cost      <= n_step.cost;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer_in) begin
            r_drive     <= n_step.drive;
            r_saturated <= n_step.saturated;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.level     = r_level;
    assign o_result.cost      = r_cost;
    assign o_result.drive     = r_drive;
    assign o_result.saturated = r_saturated;

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer_in && i_item.restart) |=>
            (r_out_valid && r_cost == '0 && !r_drive && !r_saturated))
        else $error("restart result not cleared");

    a_restart_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer_in && i_item.restart) |=> (r_level == $past(coefs.init)))
        else $error("restart did not load initial level");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("input taken while result stalled");

    a_step_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer_in && !i_item.restart) |=>
            (r_drive == ($past(r_level) < $past(coefs.thr))))
        else $error("drive does not match threshold compare");

endmodule

[src/ssoo_cfg_regs.sv]
module ssoo_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ssoo_cfg_if.sink           i_cfg,
    output ssoo_pkg::t_coefs   o_coefs
);

    ssoo_pkg::t_coefs r_coefs;

    assign i_cfg.ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.a00  <= ssoo_pkg::RST_A00;
            r_coefs.a01  <= ssoo_pkg::RST_A01;
            r_coefs.a10  <= ssoo_pkg::RST_A10;
            r_coefs.a11  <= ssoo_pkg::RST_A11;
            r_coefs.b0   <= ssoo_pkg::RST_B0;
            r_coefs.b1   <= ssoo_pkg::RST_B1;
            r_coefs.thr  <= ssoo_pkg::RST_THR;
            r_coefs.init <= ssoo_pkg::RST_INIT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ssoo_pkg::REG_A00:  r_coefs.a00  <= $signed(i_cfg.data);
                ssoo_pkg::REG_A01:  r_coefs.a01  <= $signed(i_cfg.data);
                ssoo_pkg::REG_A10:  r_coefs.a10  <= $signed(i_cfg.data);
                ssoo_pkg::REG_A11:  r_coefs.a11  <= $signed(i_cfg.data);
                ssoo_pkg::REG_B0:   r_coefs.b0   <= $signed(i_cfg.data);
                ssoo_pkg::REG_B1:   r_coefs.b1   <= $signed(i_cfg.data);
                ssoo_pkg::REG_THR:  r_coefs.thr  <= $signed(i_cfg.data);
                ssoo_pkg::REG_INIT: r_coefs.init <= $signed(i_cfg.data);
                default: ; // unmapped index: dropped
            endcase
        end
    end

endmodule

[src/ssoo_row_mac.sv]
module ssoo_row_mac (
    input  ssoo_pkg::t_fix i_coef0,
    input  ssoo_pkg::t_fix i_coef1,
    input  ssoo_pkg::t_fix i_x0,
    input  ssoo_pkg::t_fix i_x1,
    input  ssoo_pkg::t_fix i_gain,
    input  logic           i_drive,
    output ssoo_pkg::t_fix o_value,
    output logic           o_clip
);

    logic signed [ssoo_pkg::PROD_W-1:0]  p0;
    logic signed [ssoo_pkg::PROD_W-1:0]  p1;
    logic signed [ssoo_pkg::SHIFT_W-1:0] t0;
    logic signed [ssoo_pkg::SHIFT_W-1:0] t1;
    ssoo_pkg::t_fix                      bterm;
    logic signed [ssoo_pkg::SUM_W-1:0]   sum;

    assign p0 = ssoo_pkg::PROD_W'(i_coef0) * ssoo_pkg::PROD_W'(i_x0);
    assign p1 = ssoo_pkg::PROD_W'(i_coef1) * ssoo_pkg::PROD_W'(i_x1);

    // dropping the low bits of a two's complement product floors it
    assign t0 = p0[ssoo_pkg::PROD_W-1:ssoo_pkg::FRAC_BITS];
    assign t1 = p1[ssoo_pkg::PROD_W-1:ssoo_pkg::FRAC_BITS];

    assign bterm = i_drive ? i_gain : '0;

    assign sum = ssoo_pkg::SUM_W'(t0) + ssoo_pkg::SUM_W'(t1)
               + ssoo_pkg::SUM_W'(bterm);

    // fits in 32 bits only if all bits above bit 31 match the sign
    assign o_clip = !((&sum[ssoo_pkg::SUM_W-1:ssoo_pkg::DATA_W-1])
                   || !(|sum[ssoo_pkg::SUM_W-1:ssoo_pkg::DATA_W-1]));

    always_comb begin
        if (!o_clip) begin
            o_value = sum[ssoo_pkg::DATA_W-1:0];
        end else if (sum[ssoo_pkg::SUM_W-1]) begin
            o_value = ssoo_pkg::FIX_MIN;
        end else begin
            o_value = ssoo_pkg::FIX_MAX;
        end
    end

endmodule

[src/ssoo_step_calc.sv]
module ssoo_step_calc (
    input  ssoo_pkg::t_coefs i_coefs,
    input  ssoo_pkg::t_fix   i_level,
    input  ssoo_pkg::t_fix   i_cost,
    input  logic             i_restart,
    output ssoo_pkg::t_step  o_step
);

    logic           drive;
    ssoo_pkg::t_fix row0;
    ssoo_pkg::t_fix row1;
    logic           clip0;
    logic           clip1;

    assign drive = (i_level < i_coefs.thr);

    ssoo_row_mac u_row0 (
        .i_coef0 (i_coefs.a00),
        .i_coef1 (i_coefs.a01),
        .i_x0    (i_level),
        .i_x1    (i_cost),
        .i_gain  (i_coefs.b0),
        .i_drive (drive),
        .o_value (row0),
        .o_clip  (clip0)
    );

    ssoo_row_mac u_row1 (
        .i_coef0 (i_coefs.a10),
        .i_coef1 (i_coefs.a11),
        .i_x0    (i_level),
        .i_x1    (i_cost),
        .i_gain  (i_coefs.b1),
        .i_drive (drive),
        .o_value (row1),
        .o_clip  (clip1)
    );

    always_comb begin
        if (i_restart) begin
            o_step.level     = i_coefs.init;
            o_step.cost      = '0;
            o_step.drive     = 1'b0;
            o_step.saturated = 1'b0;
        end else begin
            o_step.level     = row0;
            o_step.cost      = row1;
            o_step.drive     = drive;
            o_step.saturated = clip0 | clip1;
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 100;
    localparam int LONG_HOLD   = 150;

    // indexes past the register file, must be ignored
    localparam logic [ssoo_pkg::CFG_IDX_W-1:0] IDX_PAST_END = 8'd8;
    localparam logic [ssoo_pkg::CFG_IDX_W-1:0] IDX_TOP      = 8'hff;

    typedef enum int {SET_TYPICAL, SET_RANDOM, SET_CORNER} t_setting;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ssoo_in_if  item_if ();
    ssoo_out_if result_if ();
    ssoo_cfg_if cfg_if ();

    state_space_on_off_step_unit i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // plant copy: registers and state as seen after every transfer so far
    ssoo_pkg::t_fix  plant_regs [8];
    ssoo_pkg::t_fix  level_q;
    ssoo_pkg::t_fix  cost_q;
    ssoo_pkg::t_step expected_steps [$];
    logic            restart_queue [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_reqs     = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    int   errors        = 0;
    int   cycles        = 0;
    logic item_acc      = 1'b0;
    logic cfg_acc       = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // exact product scaled back by the fraction bits, floor rounding
    function automatic logic signed [65:0] scaled_prod(input ssoo_pkg::t_fix a,
                                                       input ssoo_pkg::t_fix b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return 66'(p >>> ssoo_pkg::FRAC_BITS);
    endfunction

    function automatic ssoo_pkg::t_fix clip_sum(input logic signed [65:0] s,
                                                inout logic clipped);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'(ssoo_pkg::FIX_MAX);
        lo = 66'(ssoo_pkg::FIX_MIN);
        if (s > hi) begin
            clipped = 1'b1;
            return ssoo_pkg::FIX_MAX;
        end
        if (s < lo) begin
            clipped = 1'b1;
            return ssoo_pkg::FIX_MIN;
        end
        return s[ssoo_pkg::DATA_W-1:0];
    endfunction

    function automatic ssoo_pkg::t_step advance_plant(input logic restart);
        ssoo_pkg::t_step    r;
        logic signed [65:0] s0;
        logic signed [65:0] s1;
        logic               clipped;
        clipped = 1'b0;
        r.drive = 1'b0;
        if (restart) begin
            level_q = plant_regs[ssoo_pkg::REG_INIT];
            cost_q  = '0;
        end else begin
            r.drive = (level_q < plant_regs[ssoo_pkg::REG_THR]);
            s0 = scaled_prod(plant_regs[ssoo_pkg::REG_A00], level_q)
               + scaled_prod(plant_regs[ssoo_pkg::REG_A01], cost_q);
            s1 = scaled_prod(plant_regs[ssoo_pkg::REG_A10], level_q)
               + scaled_prod(plant_regs[ssoo_pkg::REG_A11], cost_q);
            if (r.drive) begin
                s0 = s0 + 66'(plant_regs[ssoo_pkg::REG_B0]);
                s1 = s1 + 66'(plant_regs[ssoo_pkg::REG_B1]);
            end
            level_q = clip_sum(s0, clipped);
            cost_q  = clip_sum(s1, clipped);
        end
        r.level     = level_q;
        r.cost      = cost_q;
        r.saturated = clipped;
        return r;
    endfunction

    function automatic ssoo_pkg::t_fix corner_value();
        case ($urandom_range(5))
            0:       return ssoo_pkg::FIX_MAX;
            1:       return ssoo_pkg::FIX_MIN;
            2:       return '0;
            3:       return 32'sd1;
            4:       return -32'sd1;
            default: return 32'sd65536;
        endcase
    endfunction

    // sample at the rising edge: predict on item transfers, check on result transfers
    always @(posedge clk) begin : monitor
        ssoo_pkg::t_step want;
        cycles++;
        item_acc <= rst_n && item_if.valid && item_if.ready;
        cfg_acc  <= rst_n && cfg_if.valid && cfg_if.ready;
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready && cfg_if.index <= ssoo_pkg::REG_INIT)
                plant_regs[cfg_if.index[2:0]] = cfg_if.data;
            if (result_if.valid && result_if.ready) begin
                if (expected_steps.size() == 0) begin
                    $error("result transfer with no step outstanding");
                    errors++;
                end else begin
                    want = expected_steps.pop_front();
                    if (result_if.level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, result_if.level);
                        errors++;
                    end
                    if (result_if.cost !== want.cost) begin
                        $error("cost: expected %0d, got %0d", want.cost, result_if.cost);
                        errors++;
                    end
                    if (result_if.drive !== want.drive) begin
                        $error("drive: expected %0b, got %0b", want.drive, result_if.drive);
                        errors++;
                    end
                    if (result_if.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b", want.saturated,
                               result_if.saturated);
                        errors++;
                    end
                end
            end
            if (item_if.valid && item_if.ready)
                expected_steps.push_back(advance_plant(item_if.restart));
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // item driver: holds valid until the transfer, then offers the next pending item
    always @(negedge clk) begin : feeder
        if (!item_if.valid || item_acc) begin
            if (restart_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                item_if.valid   <= 1'b1;
                item_if.restart <= restart_queue.pop_front();
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // result sink with random backpressure and requested long hold-offs
    always @(negedge clk) begin : drain
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            result_if.ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_items(input logic restart, input int count);
        repeat (count) restart_queue.push_back(restart);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (restart_queue.size() != 0 || item_if.valid || expected_steps.size() != 0);
        // result register latency
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ssoo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssoo_pkg::DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(negedge clk);
        while (!cfg_acc);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_plant(input ssoo_pkg::t_fix vals [8]);
        for (int i = 0; i < 8; i++)
            write_reg(ssoo_pkg::t_reg_idx'(i), vals[i]);
    endtask

    task automatic pick_setting(input t_setting kind, output ssoo_pkg::t_fix vals [8]);
        case (kind)
            SET_RANDOM: begin
                foreach (vals[i]) vals[i] = $urandom;
            end
            SET_CORNER: begin
                foreach (vals[i]) vals[i] = corner_value();
            end
            default: begin
                // near-stable plant with the threshold in reach, so the drive toggles
                vals[ssoo_pkg::REG_A00]  = $urandom_range(66000, 50000);
                vals[ssoo_pkg::REG_A01]  = $urandom_range(2000) - 1000;
                vals[ssoo_pkg::REG_A10]  = $urandom_range(4000) - 2000;
                vals[ssoo_pkg::REG_A11]  = $urandom_range(66000, 60000);
                vals[ssoo_pkg::REG_B0]   = $urandom_range(400000) - 100000;
                vals[ssoo_pkg::REG_B1]   = $urandom_range(655360) - 327680;
                vals[ssoo_pkg::REG_THR]  = $urandom_range(4000000) - 1000000;
                vals[ssoo_pkg::REG_INIT] = $urandom_range(4000000) - 1000000;
            end
        endcase
    endtask

    initial begin : stimulus
        ssoo_pkg::t_fix vals [8];
        t_setting       kind;
        int             restart_pct;
        item_if.valid   = 1'b0;
        item_if.restart = 1'b0;
        result_if.ready = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        plant_regs = '{ssoo_pkg::RST_A00, ssoo_pkg::RST_A01, ssoo_pkg::RST_A10,
                       ssoo_pkg::RST_A11, ssoo_pkg::RST_B0, ssoo_pkg::RST_B1,
                       ssoo_pkg::RST_THR, ssoo_pkg::RST_INIT};
        level_q = ssoo_pkg::RST_INIT;
        cost_q  = '0;
        send_idle_pct = 38;
        recv_idle_pct = 83;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset values: level climbs toward the threshold while the drive stays on
        push_items(1'b1, 1);
        push_items(1'b0, 14);
        push_items(1'b1, 1);
        push_items(1'b0, 3);
        wait_drained();

        // largest coefficients: old state first, then reload and step
        foreach (vals[i]) vals[i] = ssoo_pkg::FIX_MAX;
        load_plant(vals);
        push_items(1'b0, 1);
        push_items(1'b1, 1);
        push_items(1'b0, 1);
        wait_drained();

        // most negative: clips high, then low; stray indexes change nothing
        foreach (vals[i]) vals[i] = ssoo_pkg::FIX_MIN;
        load_plant(vals);
        write_reg(IDX_PAST_END, $urandom);
        write_reg(IDX_TOP, $urandom);
        push_items(1'b1, 1);
        push_items(1'b0, 2);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 4) begin
                send_idle_pct = 83;
                recv_idle_pct = 38;
            end
            if (ph == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph % 4)
                1:       kind = SET_RANDOM;
                2:       kind = SET_CORNER;
                default: kind = SET_TYPICAL;
            endcase
            restart_pct = (kind == SET_TYPICAL) ? 4 : 30;
            pick_setting(kind, vals);
            load_plant(vals);
            if (ph % 3 == 0)
                write_reg(ssoo_pkg::CFG_IDX_W'($urandom_range(IDX_TOP, IDX_PAST_END)),
                          $urandom);
            // sometimes keep the old state instead of restarting from the new initial level
            if ($urandom_range(3) != 0)
                push_items(1'b1, 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_items($urandom_range(99) < restart_pct, 1);
            if (ph == 6 || ph == 10) begin
                while (restart_queue.size() > PHASE_ITEMS - 10)
                    @(negedge clk);
                hold_reqs++;
            end
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
src/ssoo_pkg.sv
src/ssoo_ifs.sv
src/ssoo_cfg_regs.sv
src/ssoo_row_mac.sv
src/ssoo_step_calc.sv
src/state_space_on_off_step_unit.sv
test/testbench.sv
